FILE: rtl/rrp800_pkg.sv
// ----------------------------------------------------------------------------
// Reduced-round permutation package
// Shared types, constants and helper functions for the 800-bit permutation.
// ----------------------------------------------------------------------------
package rrp800_pkg;

   localparam int LANE_W         = 32;
   localparam int LANES          = 25;
   localparam int CNT_W          = 5;
   localparam int RC_IDX_W       = 5;
   localparam int ROUNDS_DEFAULT = 6;
   localparam logic [CNT_W-1:0] LAST_LANE_IDX = CNT_W'(LANES - 1);

   typedef logic [LANE_W-1:0] lane_type;
   typedef logic [LANES-1:0][LANE_W-1:0] state_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PERM,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic                busy;
      logic                shift_in;
      logic                step;
      logic                shift_out;
      logic                strobe;
      logic                last;
      logic [RC_IDX_W-1:0] round_idx;
   } ctrl_type;

   localparam int ROT_TAB [LANES] = '{
       0,  1, 30, 28, 27,
       4, 12,  6, 23, 20,
       3, 10, 11, 25,  7,
       9, 13, 15, 21,  8,
      18,  2, 29, 24, 14
   };

   function automatic lane_type rotl(input lane_type v, input int s);
      logic [2*LANE_W-1:0] t;
      t = {v, v} << s;
      return t[2*LANE_W-1:LANE_W];
   endfunction

   function automatic lane_type round_const(input logic [RC_IDX_W-1:0] idx);
      lane_type rc;
      case (idx)
         5'd0:    rc = 32'h00000001;
         5'd1:    rc = 32'h00008082;
         5'd2:    rc = 32'h0000808A;
         5'd3:    rc = 32'h80008000;
         5'd4:    rc = 32'h0000808B;
         5'd5:    rc = 32'h80000001;
         5'd6:    rc = 32'h80008081;
         5'd7:    rc = 32'h00008009;
         5'd8:    rc = 32'h0000008A;
         5'd9:    rc = 32'h00000088;
         5'd10:   rc = 32'h80008009;
         5'd11:   rc = 32'h8000000A;
         5'd12:   rc = 32'h8000808B;
         5'd13:   rc = 32'h0000008B;
         5'd14:   rc = 32'h00008089;
         5'd15:   rc = 32'h00008003;
         5'd16:   rc = 32'h00008002;
         5'd17:   rc = 32'h00000080;
         5'd18:   rc = 32'h0000800A;
         5'd19:   rc = 32'h8000000A;
         5'd20:   rc = 32'h80008081;
         5'd21:   rc = 32'h00008080;
         default: rc = '0;
      endcase
      return rc;
   endfunction

endpackage

FILE: rtl/rrp800_round.sv
// ----------------------------------------------------------------------------
// Permutation round unit
// One full round of theta, rho, pi, chi and iota on the 800-bit state.
// ----------------------------------------------------------------------------
module rrp800_round (
   input  rrp800_pkg::state_type               state_i,
   input  logic [rrp800_pkg::RC_IDX_W-1:0]     round_idx,
   output rrp800_pkg::state_type               state_o
);
   import rrp800_pkg::*;

   lane_type  col [5];
   lane_type  dcol [5];
   state_type th;
   state_type bp;
   state_type ch;

   always_comb begin
      for (int x = 0; x < 5; x++) begin
         col[x] = state_i[x] ^ state_i[x+5] ^ state_i[x+10] ^ state_i[x+15] ^ state_i[x+20];
      end
      for (int x = 0; x < 5; x++) begin
         dcol[x] = rotl(col[(x+1)%5], 1) ^ col[(x+4)%5];
      end
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 5; x++) begin
            th[x+5*y] = state_i[x+5*y] ^ dcol[x];
         end
      end
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 5; x++) begin
            bp[y+5*((2*x+3*y)%5)] = rotl(th[x+5*y], ROT_TAB[x+5*y]);
         end
      end
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 5; x++) begin
            ch[x+5*y] = bp[x+5*y] ^ (~bp[(x+1)%5+5*y] & bp[(x+2)%5+5*y]);
         end
      end
      state_o    = ch;
      state_o[0] = ch[0] ^ round_const(round_idx);
   end

endmodule

FILE: rtl/rrp800_seq.sv
// ----------------------------------------------------------------------------
// Permutation sequencer
// Counts loaded lanes, rounds and emitted lanes and steers the lane register.
// ----------------------------------------------------------------------------
module rrp800_seq #(
   parameter int ROUNDS = rrp800_pkg::ROUNDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output rrp800_pkg::ctrl_type ctrl
);
   import rrp800_pkg::*;

   localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic [RW-1:0]    round_ff, round_in;
   logic             accept;

   assign accept = start && (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && load_cnt_ff == LAST_LANE_IDX) state_in = ST_PERM;
         end
         ST_PERM: begin
            if (round_ff == LAST_ROUND) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_cnt_ff == LAST_LANE_IDX) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.round_idx = RC_IDX_W'(round_ff);
      ctrl.last      = (emit_cnt_ff == LAST_LANE_IDX);
      case (state_ff)
         ST_LOAD: begin
            ctrl.shift_in = accept;
         end
         ST_PERM: begin
            ctrl.busy = 1'b1;
            ctrl.step = 1'b1;
         end
         ST_EMIT: begin
            ctrl.busy      = 1'b1;
            ctrl.shift_out = 1'b1;
            ctrl.strobe    = 1'b1;
         end
         default: ctrl.busy = 1'b1;
      endcase
   end

   always_comb begin
      load_cnt_in = load_cnt_ff;
      emit_cnt_in = emit_cnt_ff;
      round_in    = round_ff;
      if (ctrl.shift_in) begin
         load_cnt_in = (load_cnt_ff == LAST_LANE_IDX) ? '0 : load_cnt_ff + 1'b1;
      end
      if (ctrl.step) begin
         round_in = (round_ff == LAST_ROUND) ? '0 : round_ff + 1'b1;
      end
      if (ctrl.shift_out) begin
         emit_cnt_in = (emit_cnt_ff == LAST_LANE_IDX) ? '0 : emit_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         emit_cnt_ff <= '0;
         round_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         emit_cnt_ff <= emit_cnt_in;
         round_ff    <= round_in;
      end
   end

   a_full_load_starts_perm: assert property (@(posedge clock) disable iff (reset)
      (ctrl.shift_in && load_cnt_ff == LAST_LANE_IDX) |=> (ctrl.step && round_ff == '0))
      else $error("permutation did not start after the last input beat");

   a_emit_contiguous: assert property (@(posedge clock) disable iff (reset)
      (ctrl.strobe && !ctrl.last) |=> ctrl.strobe)
      else $error("result beats are not contiguous");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (ctrl.strobe && ctrl.last) |=> (!ctrl.busy && load_cnt_ff == '0))
      else $error("block not idle after the last result beat");

   a_perm_to_emit: assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && round_ff == LAST_ROUND) |=> (ctrl.strobe && emit_cnt_ff == '0))
      else $error("emission did not follow the final round");

endmodule

FILE: rtl/reduced_round_permutation_800_top.sv
// ----------------------------------------------------------------------------
// Reduced-round 800-bit permutation, top level
// Loads 25 lanes, permutes them for ROUNDS rounds and returns 25 lanes.
// ----------------------------------------------------------------------------
// Lanes are loaded in order 0 to 24, one per cycle in which start is high, while
// busy is low. After the 25th lane, busy rises: the single round unit computes
// one full round per cycle for ROUNDS rounds, then the 25 result lanes leave in
// order on consecutive cycles, each marked by rsp_strobe, with rsp_last_lane set
// on lane 24. The receiver cannot stall and must take every result beat as it
// comes.
module reduced_round_permutation_800_top #(
   parameter int ROUNDS = rrp800_pkg::ROUNDS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  rrp800_pkg::lane_type     req_lane_word,
   output logic                     rsp_strobe,
   output rrp800_pkg::lane_type     rsp_lane_word_out,
   output logic                     rsp_last_lane
);
   import rrp800_pkg::*;

   ctrl_type  ctrl;
   state_type lanes_ff, lanes_in;
   state_type round_out;

   rrp800_seq #(.ROUNDS(ROUNDS)) u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .ctrl  (ctrl)
   );

   rrp800_round u_round (
      .state_i   (lanes_ff),
      .round_idx (ctrl.round_idx),
      .state_o   (round_out)
   );

   always_comb begin
      lanes_in = lanes_ff;
      if (ctrl.step) begin
         lanes_in = round_out;
      end else if (ctrl.shift_in || ctrl.shift_out) begin
         for (int i = 0; i < LANES - 1; i++) begin
            lanes_in[i] = lanes_ff[i+1];
         end
         lanes_in[LANES-1] = req_lane_word;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
   end

   assign busy              = ctrl.busy;
   assign rsp_strobe        = ctrl.strobe;
   assign rsp_lane_word_out = lanes_ff[0];
   assign rsp_last_lane     = ctrl.last;

endmodule
